/* hdl/arbd_pkg.sv */
package arbd_pkg;

  localparam int unsigned CHUNK_WORDS  = 4096;
  localparam int unsigned CHUNK_COUNT  = 8;
  localparam int unsigned MAX_CHANNELS = 6;
  localparam int unsigned MAX_PERIOD   = 8192;
  localparam int unsigned RING_WORDS   = (CHUNK_COUNT + 1) * CHUNK_WORDS;
  localparam int unsigned MAX_USED     = CHUNK_COUNT * CHUNK_WORDS;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned FC_W   = 14;
  localparam int unsigned CH_W   = 3;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned PTR_W  = $clog2(RING_WORDS);

  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PERIOD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PULL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESUME = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd6;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_PERIOD,
    OP_PULL,
    OP_PAUSE,
    OP_RESUME,
    OP_FLUSH,
    OP_QUERY
  } op_e;

  typedef struct packed {
    op_e               kind;
    logic [WORD_W-1:0] word;
    logic [FC_W-1:0]   frames;
  } op_t;

  localparam logic signed [PTR_W+1:0] RING_S  = (PTR_W+2)'(RING_WORDS);
  localparam logic signed [PTR_W+1:0] CHUNK_S = (PTR_W+2)'(CHUNK_WORDS);

  function automatic logic [CNT_W-1:0] used_of(input logic [PTR_W-1:0] rp,
                                               input logic [PTR_W-1:0] wp);
    logic signed [PTR_W+1:0] d;
    d = $signed({2'b00, wp}) - $signed({2'b00, rp});
    if (d < 0) d = d + RING_S;
    return d[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] free_of(input logic [PTR_W-1:0] rp,
                                               input logic [PTR_W-1:0] wp);
    logic signed [PTR_W+1:0] d;
    d = $signed({2'b00, rp}) - $signed({2'b00, wp}) - CHUNK_S;
    if (d < 0) d = d + RING_S;
    if (d < 0) d = '0;
    return d[CNT_W-1:0];
  endfunction

  // Advance a ring pointer by n words, wrapping at the ring size.
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [CH_W-1:0]  n);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W+1)'(n);
    if (s >= (PTR_W+1)'(RING_WORDS)) s = s - (PTR_W+1)'(RING_WORDS);
    return s[PTR_W-1:0];
  endfunction

endpackage

/* hdl/audio_ring_buffer_deinterleaver_unit.sv */
// Audio output FIFO with channel deinterleaving. Interleaved 32-bit sample
// words are written into a ring of (CHUNK_COUNT + 1) * CHUNK_WORDS entries, of
// which one chunk always stays empty, so at most CHUNK_COUNT * CHUNK_WORDS words
// are buffered. A period start sets how many frames the following frame pulls
// may take; a shortfall latches underrun, which the next write clears. Each
// frame pull returns one beat per channel (channel_index 0 up to channels - 1,
// last on the final one), zeros when paused, out of frames or short of a frame;
// every other command returns a single beat. All beats carry the latch and the
// free and used counts as they stand after the command. A two-entry command
// queue decouples the input from the executing side, so the input keeps taking
// commands while output beats wait: two sit in the queue, and one more is
// carried out and held until the output register frees up. On the executing
// side a frame pull makes one store read per cycle while the output is not
// stalled, overlapped with the output register, and a period start with a
// shortfall runs used / channels through a 16-step bit-serial divider. The
// sample store is not cleared at reset; only words that were written are ever
// read. The channel count register may be written only while no command is in
// flight; 0 acts as 1 and values above MAX_CHANNELS act as MAX_CHANNELS.
module audio_ring_buffer_deinterleaver_unit import arbd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CH_W-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [WORD_W-1:0] sample_word_i,
  input  logic [FC_W-1:0]   frame_count_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] out_sample_o,
  output logic [CH_W-1:0]   channel_index_o,
  output logic              last_o,
  output logic              accepted_o,
  output logic              underrun_flag_o,
  output logic [CNT_W-1:0]  free_words_o,
  output logic [CNT_W-1:0]  used_words_o
);

  logic [CH_W-1:0] channels_q, channels_d;
  logic [CH_W-1:0] ch_eff;
  logic            q_valid, q_pop;
  op_t             q_op;

  // Hold the channel count; load it on a configuration write.
  assign channels_d = cfg_we_i ? cfg_wdata_i : channels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q <= CH_W'(2);
    end else begin
      channels_q <= channels_d;
    end
  end

  // Clamp out-of-range channel counts into 1..MAX_CHANNELS.
  always_comb begin
    priority if (channels_q == '0) begin
      ch_eff = CH_W'(1);
    end else if (channels_q > CH_W'(MAX_CHANNELS)) begin
      ch_eff = CH_W'(MAX_CHANNELS);
    end else begin
      ch_eff = channels_q;
    end
  end

  arbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .sample_word_i(sample_word_i),
    .frame_count_i(frame_count_i),
    .q_valid_o    (q_valid),
    .q_op_o       (q_op),
    .q_pop_i      (q_pop)
  );

  arbd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ch_i           (ch_eff),
    .q_valid_i      (q_valid),
    .q_op_i         (q_op),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_sample_o   (out_sample_o),
    .channel_index_o(channel_index_o),
    .last_o         (last_o),
    .accepted_o     (accepted_o),
    .underrun_flag_o(underrun_flag_o),
    .free_words_o   (free_words_o),
    .used_words_o   (used_words_o)
  );

endmodule

/* hdl/arbd_ram.sv */
module arbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/arbd_front.sv */
module arbd_front import arbd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [WORD_W-1:0] sample_word_i,
  input  logic [FC_W-1:0]   frame_count_i,
  output logic              q_valid_o,
  output op_t               q_op_o,
  input  logic              q_pop_i
);

  op_t        ent_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  op_t        op_in;
  logic       push;

  // Classify the command and clamp the period length.
  always_comb begin
    op_in.word   = sample_word_i;
    op_in.frames = (frame_count_i > FC_W'(MAX_PERIOD)) ? FC_W'(MAX_PERIOD) : frame_count_i;
    unique case (command_i)
      CMD_WRITE:  op_in.kind = OP_WRITE;
      CMD_PERIOD: op_in.kind = OP_PERIOD;
      CMD_PULL:   op_in.kind = OP_PULL;
      CMD_PAUSE:  op_in.kind = OP_PAUSE;
      CMD_RESUME: op_in.kind = OP_RESUME;
      CMD_FLUSH:  op_in.kind = OP_FLUSH;
      default:    op_in.kind = OP_QUERY;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_op_o     = ent_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = q_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= op_in;
  end

endmodule

/* hdl/arbd_back.sv */
module arbd_back import arbd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CH_W-1:0]   ch_i,
  input  logic              q_valid_i,
  input  op_t               q_op_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] out_sample_o,
  output logic [CH_W-1:0]   channel_index_o,
  output logic              last_o,
  output logic              accepted_o,
  output logic              underrun_flag_o,
  output logic [CNT_W-1:0]  free_words_o,
  output logic [CNT_W-1:0]  used_words_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RESP = 2'd1;
  localparam logic [1:0] S_PULL = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  localparam int unsigned DSTEP_W = $clog2(CNT_W);

  logic [1:0]         st_q, st_d;
  logic [PTR_W-1:0]   rp_q, rp_d, wp_q, wp_d, ra_q, ra_d;
  logic               paused_q, paused_d, under_q, under_d;
  logic [FC_W-1:0]    fa_q, fa_d;
  logic               acc_q, acc_d, live_q, live_d, rdv_q, rdv_d;
  logic [CH_W-1:0]    j_q, j_d;
  logic [CNT_W-1:0]   dn_q, dn_d, dq_q, dq_d;
  logic [CH_W-1:0]    dr_q, dr_d;
  logic [DSTEP_W-1:0] dc_q, dc_d;

  logic               ov_q, ov_d;
  logic [WORD_W-1:0]  osmp_q, osmp_d;
  logic [CH_W-1:0]    och_q, och_d;
  logic               olast_q, olast_d, oacc_q, oacc_d;

  logic [CNT_W-1:0]   used_cur, free_cur;
  logic [CNT_W:0]     prod;
  logic [CH_W:0]      dr2;
  logic [CNT_W-1:0]   dq_nx;
  logic               slot_free, load, we, re;
  logic [WORD_W-1:0]  rdata;

  assign used_cur  = used_of(rp_q, wp_q);
  assign free_cur  = free_of(rp_q, wp_q);
  assign slot_free = !ov_q || !out_stall_i;
  assign prod      = (CNT_W+1)'(q_op_i.frames) * (CNT_W+1)'(ch_i);
  assign dr2       = {dr_q, dn_q[CNT_W-1]};
  assign dq_nx     = {dq_q[CNT_W-2:0], (dr2 >= (CH_W+1)'(ch_i))};

  arbd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(RING_WORDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wp_q),
    .wdata_i(q_op_i.word),
    .re_i   (re),
    .raddr_i(ra_q),
    .rdata_o(rdata)
  );

  always_comb begin
    st_d = st_q;  rp_d = rp_q;  wp_d = wp_q;  ra_d = ra_q;
    paused_d = paused_q;  under_d = under_q;  fa_d = fa_q;
    acc_d = acc_q;  live_d = live_q;  rdv_d = rdv_q;  j_d = j_q;
    dn_d = dn_q;  dq_d = dq_q;  dr_d = dr_q;  dc_d = dc_q;
    q_pop_o = 1'b0;  we = 1'b0;  re = 1'b0;  load = 1'b0;
    osmp_d = '0;  och_d = '0;  olast_d = 1'b1;  oacc_d = acc_q;

    unique case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          acc_d   = 1'b1;
          st_d    = S_RESP;
          unique case (q_op_i.kind)
            OP_WRITE: begin
              under_d = 1'b0;
              if (free_cur != '0) begin
                we   = 1'b1;
                wp_d = ptr_add(wp_q, CH_W'(1));
              end else begin
                acc_d = 1'b0;
              end
            end
            OP_PERIOD: begin
              if (paused_q || under_q) begin
                fa_d = '0;
              end else if (prod > (CNT_W+1)'(used_cur)) begin
                // Shortfall: latch underrun, take used / channels frames.
                under_d = 1'b1;
                dn_d    = used_cur;
                dq_d    = '0;
                dr_d    = '0;
                dc_d    = '0;
                st_d    = S_DIV;
              end else begin
                fa_d = q_op_i.frames;
              end
            end
            OP_PULL: begin
              live_d = !paused_q && (fa_q != '0) && (used_cur >= CNT_W'(ch_i));
              ra_d   = rp_q;
              j_d    = '0;
              rdv_d  = 1'b0;
              st_d   = S_PULL;
              if (live_d) begin
                rp_d = ptr_add(rp_q, ch_i);
                fa_d = fa_q - FC_W'(1);
              end
            end
            OP_PAUSE:  paused_d = 1'b1;
            OP_RESUME: paused_d = 1'b0;
            OP_FLUSH: begin
              rp_d     = '0;
              wp_d     = '0;
              paused_d = 1'b0;
              fa_d     = '0;
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        if (slot_free) begin
          load = 1'b1;
          st_d = S_IDLE;
        end
      end
      S_PULL: begin
        oacc_d  = 1'b1;
        osmp_d  = live_q ? rdata : '0;
        och_d   = j_q;
        olast_d = (j_q == ch_i - CH_W'(1));
        if (!rdv_q) begin
          re    = live_q;
          ra_d  = ptr_add(ra_q, CH_W'(1));
          rdv_d = 1'b1;
        end else if (slot_free) begin
          load = 1'b1;
          if (olast_d) begin
            rdv_d = 1'b0;
            st_d  = S_IDLE;
          end else begin
            // Fetch the next channel while this one goes out.
            re   = live_q;
            ra_d = ptr_add(ra_q, CH_W'(1));
            j_d  = j_q + CH_W'(1);
          end
        end
      end
      S_DIV: begin
        dn_d = dn_q << 1;
        dq_d = dq_nx;
        dr_d = dq_nx[0] ? CH_W'(dr2 - (CH_W+1)'(ch_i)) : dr2[CH_W-1:0];
        dc_d = dc_q + DSTEP_W'(1);
        if (dc_q == DSTEP_W'(CNT_W - 1)) begin
          fa_d = dq_nx[FC_W-1:0];
          st_d = S_RESP;
        end
      end
      default: st_d = S_IDLE;
    endcase

    ov_d = load ? 1'b1 : (out_stall_i ? ov_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      rp_q     <= '0;
      wp_q     <= '0;
      paused_q <= 1'b0;
      under_q  <= 1'b0;
      fa_q     <= '0;
      rdv_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      rp_q     <= rp_d;
      wp_q     <= wp_d;
      paused_q <= paused_d;
      under_q  <= under_d;
      fa_q     <= fa_d;
      rdv_q    <= rdv_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q   <= ra_d;
    acc_q  <= acc_d;
    live_q <= live_d;
    j_q    <= j_d;
    dn_q   <= dn_d;
    dq_q   <= dq_d;
    dr_q   <= dr_d;
    dc_q   <= dc_d;
    if (load) begin
      osmp_q  <= osmp_d;
      och_q   <= och_d;
      olast_q <= olast_d;
      oacc_q  <= oacc_d;
      underrun_flag_o <= under_q;
      free_words_o    <= free_cur;
      used_words_o    <= used_cur;
    end
  end

  assign out_valid_o     = ov_q;
  assign out_sample_o    = osmp_q;
  assign channel_index_o = och_q;
  assign last_o          = olast_q;
  assign accepted_o      = oacc_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_cur <= CNT_W'(MAX_USED))
    else $error("buffered words exceed ring capacity");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rp_q < PTR_W'(RING_WORDS)) && (wp_q < PTR_W'(RING_WORDS)))
    else $error("ring pointer out of range");

  a_div_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> under_q)
    else $error("divider running without underrun latched");

  a_fa_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fa_q <= FC_W'(MAX_PERIOD))
    else $error("frames available exceed period limit");

  a_no_early_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_PULL && load && !olast_d) |-> ((j_q + CH_W'(1)) < ch_i))
    else $error("frame ended before its last channel");

endmodule
